@@ rtl/lvs_pkg.sv @@
// Package for the LRU victim select block: sizes, order word type, result beat type.
// No dependencies; used by lvs_order_calc and lru_victim_select_prefer_clean_unit.
package lvs_pkg;

    localparam int SET_COUNT = 64;
    localparam int WAYS      = 8;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WCMP_W    = (WAY_W > 3) ? WAY_W : 3;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

    typedef struct packed {
        logic [2:0] victim_way;
        logic       victim_clean;
        logic       updated;
    } lvs_result_t;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    function automatic order_t init_order();
        order_t o;
        for (int i = 0; i < WAYS; i++)
        begin
            o[i] = WAY_W'(i);
        end
        return o;
    endfunction

endpackage

@@ rtl/lvs_order_calc.sv @@
// Recency update and victim pick for one set's order word.
// Depends on lvs_pkg.
module lvs_order_calc (
    input  lvs_pkg::order_t      order_in,
    input  logic                 cmd,
    input  logic                 set_ok,
    input  logic [2:0]           hit_way,
    input  logic                 hit_valid,
    input  logic [7:0]           clean_mask,
    input  logic                 prefer_clean,
    output lvs_pkg::order_t      order_out,
    output logic                 wr_en,
    output lvs_pkg::lvs_result_t result
);
    import lvs_pkg::*;

    logic [WCMP_W-1:0] way_ext;
    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   clean;
    logic              touch;
    logic              suf;
    logic              found;
    logic [WAY_W-1:0]  sel;
    logic [WCMP_W-1:0] sel_ext;
    logic [WCMP_W-1:0] ent_ext;

    always_comb
    begin
        way_ext   = WCMP_W'(hit_way);
        touch     = (cmd == CMD_ACCESS) && set_ok && hit_valid && (32'(hit_way) < WAYS);
        order_out = order_in;
        suf       = 1'b0;
        found     = 1'b0;
        sel       = order_in[WAYS-1];
        ent_ext   = '0;

        for (int i = 0; i < WAYS; i++)
        begin
            ent_ext  = WCMP_W'(order_in[i]);
            match[i] = (ent_ext == way_ext);
            clean[i] = (32'(order_in[i]) < 8) && clean_mask[ent_ext[2:0]];
        end

        for (int i = WAYS - 1; i > 0; i--)
        begin
            suf = suf | match[i];
            if (suf)
                order_out[i] = order_in[i-1];
        end
        if (suf || match[0])
            order_out[0] = WAY_W'(hit_way);

        for (int i = 0; i < WAYS; i++)
        begin
            if (clean[i])
            begin
                found = 1'b1;
                sel   = order_in[i];
            end
        end
        if (!(prefer_clean && found))
            sel = order_in[WAYS-1];
        sel_ext = WCMP_W'(sel);

        wr_en  = touch;
        result = '0;
        if (cmd == CMD_ACCESS)
        begin
            result.updated = touch;
        end
        else if (set_ok)
        begin
            result.victim_way   = sel_ext[2:0];
            result.victim_clean = prefer_clean && found;
        end
    end

endmodule

@@ rtl/lru_victim_select_prefer_clean_unit.sv @@
// Top level: true-LRU order store per set with victim select, optional prefer-clean.
// Depends on lvs_pkg and lvs_order_calc.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per access or victim query.
//   Output channel (out_valid/out_stall) returns exactly one result beat per input.
//   Config channel (cfg_valid/cfg_ready, data prefer_clean) writes the mode bit;
//   cfg_ready is always high. Write it only while the block is idle.
// Result: registered in ST_CALC after its input beat is taken, once the output
//   register is free or being taken. No new item is taken until the read-modify-write
//   of the order memory is done (read as the beat is taken, update and write back in ST_CALC).
// The next input beat is taken while the previous result still waits in the
//   output register; the update of a held-up item waits until that register frees.
// Reset: no memory sweep. A valid bit per set marks sets written since reset;
//   an unwritten set reads as ways 0..WAYS-1 in order. Mode resets to plain LRU.
// Receiver stall: out_valid and the result beat hold until taken; the block then
//   holds in_stall high once its next item is ready to deliver.
module lru_victim_select_prefer_clean_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [5:0] set_index,
    input  logic [2:0] hit_way,
    input  logic       hit_valid,
    input  logic [7:0] clean_mask,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] victim_way,
    output logic       victim_clean,
    output logic       updated,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       prefer_clean
);
    import lvs_pkg::*;

    order_t               order_mem [SET_COUNT];
    logic [SET_COUNT-1:0] set_vld_reg;

    state_t              state_reg, state_next;
    logic                prefer_clean_reg;
    logic                out_valid_reg, out_valid_next;
    lvs_result_t         res_reg;

    logic                cmd_reg;
    logic [SET_W-1:0]    set_reg;
    logic                set_ok_reg;
    logic [2:0]          way_reg;
    logic                hv_reg;
    logic [7:0]          mask_reg;
    order_t              rd_data_reg;
    logic                rd_vld_reg;

    logic                in_take;
    logic                finish;
    logic [SET_W-1:0]    in_set;
    order_t              cur_order;
    order_t              new_order;
    logic                wr_en;
    lvs_result_t         calc_res;

    assign cfg_ready = 1'b1;
    assign in_set    = SET_W'(set_index);
    assign cur_order = rd_vld_reg ? rd_data_reg : init_order();

    lvs_order_calc u_calc (
        .order_in     (cur_order),
        .cmd          (cmd_reg),
        .set_ok       (set_ok_reg),
        .hit_way      (way_reg),
        .hit_valid    (hv_reg),
        .clean_mask   (mask_reg),
        .prefer_clean (prefer_clean_reg),
        .order_out    (new_order),
        .wr_en        (wr_en),
        .result       (calc_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        finish         = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    finish         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_take = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            prefer_clean_reg <= 1'b0;
            set_vld_reg      <= '0;
            rd_vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                prefer_clean_reg <= prefer_clean;
            if (in_take)
                rd_vld_reg <= set_vld_reg[in_set];
            if (finish && wr_en)
                set_vld_reg[set_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg     <= cmd;
            set_reg     <= in_set;
            set_ok_reg  <= (32'(set_index) < SET_COUNT);
            way_reg     <= hit_way;
            hv_reg      <= hit_valid;
            mask_reg    <= clean_mask;
            rd_data_reg <= order_mem[in_set];
        end
        if (finish && wr_en)
            order_mem[set_reg] <= new_order;
        if (finish)
            res_reg <= calc_res;
    end

    assign out_valid    = out_valid_reg;
    assign victim_way   = res_reg.victim_way;
    assign victim_clean = res_reg.victim_clean;
    assign updated      = res_reg.updated;

endmodule
